@@ rtl/button_debounce_long_hold_assert.svh @@
// Assertion macros for the button debouncer RTL.
`ifndef BUTTON_DEBOUNCE_LONG_HOLD_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_HOLD_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BDLH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDLH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bdlh_pkg.sv @@
// Shared types and constants for the button debouncer with long-hold detection.
package bdlh_pkg;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned DEB_W  = 8;
   localparam int unsigned REP_W  = 8;
   localparam int unsigned SRC_W  = 8;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned CSR_W  = 16;

   localparam logic [IDX_W-1:0] CSR_DEBOUNCE  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_LONG_HOLD = 3'd1;
   localparam logic [IDX_W-1:0] CSR_REPEAT    = 3'd2;
   localparam logic [IDX_W-1:0] CSR_REP_EN    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_SOURCE    = 3'd4;

   localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 8'd75;
   localparam logic [TIME_W-1:0] LONG_HOLD_RST = 16'd1000;
   localparam logic [REP_W-1:0]  REPEAT_RST    = 8'd200;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_LONG    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [DEB_W-1:0]  debounce_ms;
      logic [TIME_W-1:0] long_hold_ms;
      logic [REP_W-1:0]  repeat_ms;
      logic              repeat_enable;
      logic [SRC_W-1:0]  source_value;
   } cfg_type;

   typedef struct packed {
      kind_type         event_kind;
      logic [SRC_W-1:0] event_value;
      logic             is_active;
      logic             is_long_hold;
   } result_type;

endpackage

@@ rtl/bdlh_step.sv @@
// Per-poll debounce and long-hold logic with the button state registers.
module bdlh_step import bdlh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              pin_level,
   input  cfg_type           cfg,
   output result_type        result
);

   logic [TIME_W-1:0] toggle_time_ff, toggle_time_in;
   logic [TIME_W-1:0] repeat_time_ff, repeat_time_in;
   logic              raw_last_ff, raw_last_in;
   logic              stable_ff, stable_in;
   logic              hold_ff, hold_in;

   logic [TIME_W-1:0] toggle_eff;
   logic [TIME_W-1:0] held;
   logic [TIME_W-1:0] since_rep;
   logic              steady;
   kind_type          kind;

   always_comb begin
      toggle_eff     = (pin_level != raw_last_ff) ? now_ms : toggle_time_ff;
      held           = now_ms - toggle_eff;
      since_rep      = now_ms - repeat_time_ff;
      steady         = held > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms};
      toggle_time_in = toggle_eff;
      repeat_time_in = repeat_time_ff;
      raw_last_in    = pin_level;
      stable_in      = stable_ff;
      hold_in        = hold_ff;
      kind           = KIND_NONE;
      if (steady) begin
         stable_in = pin_level;
         if (pin_level != stable_ff) begin
            if (!pin_level) begin
               repeat_time_in = now_ms;
               kind           = KIND_PRESS;
            end else begin
               toggle_time_in = '0;
               repeat_time_in = '0;
               hold_in        = 1'b0;
               kind           = KIND_RELEASE;
            end
         end else if (!pin_level && (held > cfg.long_hold_ms) &&
                      (since_rep > {{(TIME_W-REP_W){1'b0}}, cfg.repeat_ms})) begin
            hold_in = 1'b1;
            // first long hold always reports, later ones only with repeat on
            if (!hold_ff || cfg.repeat_enable) begin
               kind           = KIND_LONG;
               repeat_time_in = now_ms;
            end
         end
      end
      result.event_kind   = kind;
      result.event_value  = (kind != KIND_NONE) ? cfg.source_value : '0;
      result.is_active    = ~stable_in;
      result.is_long_hold = hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_time_ff <= '0;
         repeat_time_ff <= '0;
         raw_last_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         hold_ff        <= 1'b0;
      end else if (advance) begin
         toggle_time_ff <= toggle_time_in;
         repeat_time_ff <= repeat_time_in;
         raw_last_ff    <= raw_last_in;
         stable_ff      <= stable_in;
         hold_ff        <= hold_in;
      end
   end

endmodule

@@ rtl/button_debounce_long_hold.sv @@
// Top level: button debouncer with press/release and long-hold events.
//
//   channel  direction  carries
//   req_     in         tdata: now_ms[15:0], pin_level[16], zero pad to 24 bits
//   rsp_     out        tuser: event_kind; tdata: event_value, is_active, is_long_hold
//   csr_     in         csr_index selects register 0..4, csr_data holds its value
//
// One word in and one word out per cycle while rsp_ is not stalled; a word passes the
// input register, then the step logic, then the result register.
// Button state registers update when a word moves into the result register.
// A stalled rsp_ side holds the result; one more word waits in the input register.
// Reset restores the register defaults and the released button state.
`include "button_debounce_long_hold_assert.svh"

module button_debounce_long_hold import bdlh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // now_ms[15:0], pin_level[16], zero [23:17]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // event_value[7:0], is_active[8],
                                          // is_long_hold[9], zero [15:10]
   output logic [1:0]        rsp_tuser,   // event_kind[1:0]
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   cfg_type           cfg_ff;
   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_level_ff;
   logic              rsp_valid_ff;
   result_type        rsp_result_ff;
   result_type        step_result;
   logic              advance;

   assign csr_ready  = 1'b1;
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RST;
         cfg_ff.long_hold_ms  <= LONG_HOLD_RST;
         cfg_ff.repeat_ms     <= REPEAT_RST;
         cfg_ff.repeat_enable <= 1'b0;
         cfg_ff.source_value  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE:  cfg_ff.debounce_ms   <= csr_data[DEB_W-1:0];
            CSR_LONG_HOLD: cfg_ff.long_hold_ms  <= csr_data[TIME_W-1:0];
            CSR_REPEAT:    cfg_ff.repeat_ms     <= csr_data[REP_W-1:0];
            CSR_REP_EN:    cfg_ff.repeat_enable <= csr_data[0];
            CSR_SOURCE:    cfg_ff.source_value  <= csr_data[SRC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_now_ff   <= req_tdata[TIME_W-1:0];
         s1_level_ff <= req_tdata[TIME_W];
      end
   end

   bdlh_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .now_ms    (s1_now_ff),
      .pin_level (s1_level_ff),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.event_kind;
   assign rsp_tdata  = {6'd0, rsp_result_ff.is_long_hold, rsp_result_ff.is_active,
                        rsp_result_ff.event_value};

   `BDLH_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_tvalid, "step result lost")
   `BDLH_ASSERT_NOW(a_none_zero, clock, reset, rsp_tvalid && (rsp_tuser == KIND_NONE), rsp_tdata[7:0] == 8'd0, "value on no event")
   `BDLH_ASSERT_NOW(a_hold_active, clock, reset, rsp_tvalid && rsp_tdata[9], rsp_tdata[8], "long hold while released")
   `BDLH_ASSERT_NOW(a_release_clear, clock, reset, rsp_tvalid && (rsp_tuser == KIND_RELEASE), !rsp_tdata[8] && !rsp_tdata[9], "release left flags set")
   `BDLH_ASSERT_NOW(a_long_flags, clock, reset, rsp_tvalid && (rsp_tuser == KIND_LONG), rsp_tdata[8] && rsp_tdata[9], "long hold without flags")

endmodule

@@ bench/tb_button_debounce_long_hold.sv @@
// Self-checking testbench for the button debouncer: predicted events checked against rsp_ words.
`timescale 1ns / 1ps

module tb_button_debounce_long_hold;
   import bdlh_pkg::*;

   // first index past the register map; writes there must change nothing
   localparam logic [IDX_W-1:0] CSR_NONE = CSR_SOURCE + 1'b1;

   class button_tracker;
      logic [DEB_W-1:0]  debounce;
      logic [TIME_W-1:0] long_hold;
      logic [REP_W-1:0]  repeat_gap;
      logic              repeat_on;
      logic [SRC_W-1:0]  source_id;
      logic [TIME_W-1:0] toggle_at;
      logic [TIME_W-1:0] last_event_at;
      logic              raw_level;
      logic              stable_level;
      logic              active;
      logic              holding;
      result_type        pending_events[$];
      int unsigned       mismatch_count;
      int unsigned       checked;

      function new();
         debounce       = DEBOUNCE_RST;
         long_hold      = LONG_HOLD_RST;
         repeat_gap     = REPEAT_RST;
         repeat_on      = 1'b0;
         source_id      = '0;
         toggle_at      = '0;
         last_event_at  = '0;
         raw_level      = 1'b1;
         stable_level   = 1'b1;
         active         = 1'b0;
         holding        = 1'b0;
         mismatch_count = 0;
         checked        = 0;
      endfunction

      function void apply_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_DEBOUNCE:  debounce   = data[DEB_W-1:0];
            CSR_LONG_HOLD: long_hold  = data[TIME_W-1:0];
            CSR_REPEAT:    repeat_gap = data[REP_W-1:0];
            CSR_REP_EN:    repeat_on  = data[0];
            CSR_SOURCE:    source_id  = data[SRC_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_poll(logic [TIME_W-1:0] now, logic lvl);
         result_type        r;
         logic [TIME_W-1:0] since_toggle;
         logic [TIME_W-1:0] since_event;
         r.event_kind = KIND_NONE;
         if (lvl != raw_level) begin
            toggle_at = now;
            raw_level = lvl;
         end
         since_toggle = now - toggle_at;
         since_event  = now - last_event_at;
         if (since_toggle > TIME_W'(debounce)) begin
            if (lvl != stable_level) begin
               stable_level = lvl;
               if (!lvl) begin
                  last_event_at = now;
                  active        = 1'b1;
                  r.event_kind  = KIND_PRESS;
               end else begin
                  toggle_at     = '0;
                  last_event_at = '0;
                  active        = 1'b0;
                  holding       = 1'b0;
                  r.event_kind  = KIND_RELEASE;
               end
            end else if (!lvl && since_toggle > long_hold &&
                         since_event > TIME_W'(repeat_gap)) begin
               // without repeat only the first crossing reports
               if (!holding || repeat_on) begin
                  r.event_kind  = KIND_LONG;
                  last_event_at = now;
               end
               holding = 1'b1;
            end
         end
         r.event_value  = (r.event_kind != KIND_NONE) ? source_id : '0;
         r.is_active    = active;
         r.is_long_hold = holding;
         pending_events.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= 100)
            $display("rsp word %0d: %s", checked, msg);
      endtask

      task check_event(result_type got);
         result_type want;
         checked++;
         if (pending_events.size() == 0) begin
            report_mismatch("word arrived with nothing pending");
            return;
         end
         want = pending_events.pop_front();
         if (got.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %0d, expected %0d",
                                      got.event_kind, want.event_kind));
         if (got.event_value !== want.event_value)
            report_mismatch($sformatf("event_value got %0h, expected %0h",
                                      got.event_value, want.event_value));
         if (got.is_active !== want.is_active)
            report_mismatch($sformatf("is_active got %0b, expected %0b",
                                      got.is_active, want.is_active));
         if (got.is_long_hold !== want.is_long_hold)
            report_mismatch($sformatf("is_long_hold got %0b, expected %0b",
                                      got.is_long_hold, want.is_long_hold));
      endtask
   endclass

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;   // now_ms[15:0], pin_level[16], zero [23:17]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;         // event_value[7:0], is_active[8], is_long_hold[9]
   logic [1:0]        rsp_tuser;         // event_kind[1:0]
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]  csr_data   = '0;

   button_tracker     tracker = new();
   logic [TIME_W-1:0] now_ms = '0;
   int unsigned       gap_max = 2;
   int unsigned       stall_max = 2;
   int unsigned       polls_sent = 0;

   button_debounce_long_hold uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_poll(logic [TIME_W-1:0] stamp, logic lvl);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, lvl, stamp};
      do @(posedge clock); while (!req_tready);
      tracker.note_poll(stamp, lvl);
      polls_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   // csr_valid is dropped after each write, keeping it to a single update per call
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.apply_reg(idx, data);
      @(posedge clock);
   endtask

   // upper data bits above each register's width are junk and must be dropped
   task automatic configure(logic [DEB_W-1:0] deb, logic [TIME_W-1:0] hold,
                            logic [REP_W-1:0] rep, logic en, logic [SRC_W-1:0] src);
      settle();
      write_reg(IDX_W'($urandom_range(CSR_NONE, 2**IDX_W - 1)), CSR_W'($urandom));
      write_reg(CSR_DEBOUNCE, {8'($urandom), deb});
      write_reg(CSR_LONG_HOLD, hold);
      write_reg(CSR_REPEAT, {8'($urandom), rep});
      write_reg(CSR_REP_EN, {15'($urandom), en});
      write_reg(CSR_SOURCE, {8'($urandom), src});
   endtask

   task automatic hold_level(logic lvl, int unsigned span, int unsigned step_max);
      int unsigned spent;
      int unsigned step;
      spent = 0;
      while (spent < span) begin
         step   = $urandom_range(1, step_max);
         now_ms = now_ms + TIME_W'(step);
         spent  = spent + step;
         send_poll(now_ms, lvl);
      end
   endtask

   // contact bounce: up to four polls alternating settle_lvl and its opposite, starting on settle_lvl
   task automatic chatter(logic settle_lvl);
      int unsigned n;
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         now_ms = now_ms + TIME_W'($urandom_range(0, tracker.debounce / 2 + 1));
         send_poll(now_ms, (i % 2 == 0) ? settle_lvl : ~settle_lvl);
      end
   endtask

   task automatic press_gesture();
      int unsigned deb;
      int unsigned span;
      deb  = tracker.debounce;
      span = deb + 1 + ((tracker.long_hold < 16'd2000) ?
                        tracker.long_hold + 3 * tracker.repeat_gap : 400);
      chatter(1'b0);
      if ($urandom_range(0, 3) == 0)
         hold_level(1'b0, $urandom_range(0, deb + 1), deb / 4 + 1);
      else
         hold_level(1'b0, $urandom_range(span / 2, span + 40), span / 12 + 1);
      chatter(1'b1);
      hold_level(1'b1, deb + 1 + $urandom_range(0, 40), (deb + 40) / 6 + 1);
   endtask

   task automatic noise_burst();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0)
            now_ms = TIME_W'($urandom);
         else
            now_ms = now_ms + TIME_W'($urandom_range(0, 300));
         send_poll(now_ms, 1'($urandom));
      end
   endtask

   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_event(result_type'{kind_type'(rsp_tuser), rsp_tdata[7:0],
                                          rsp_tdata[8], rsp_tdata[9]});
   end

   initial begin
      int unsigned       phase_end;
      bit                paused;
      logic [DEB_W-1:0]  deb;
      logic [TIME_W-1:0] hold;
      logic [REP_W-1:0]  rep;
      logic              en;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: debounce 75, long hold 1000, repeat off
      send_poll(16'd0, 1'b1);
      send_poll(16'hFFFF, 1'b1);
      send_poll(16'd100, 1'b0);
      send_poll(16'd175, 1'b0);      // exactly the debounce time, still no press
      send_poll(16'd176, 1'b0);
      send_poll(16'd1100, 1'b0);     // exactly the long-hold time
      send_poll(16'd1101, 1'b0);
      send_poll(16'd1400, 1'b0);     // held on, repeat disabled
      send_poll(16'd1410, 1'b1);
      send_poll(16'd1486, 1'b1);

      // all thresholds zero, repeat on, junk above each field
      settle();
      write_reg(CSR_NONE, 16'hFFFF);
      write_reg(CSR_SOURCE, 16'h3CA5);
      write_reg(CSR_DEBOUNCE, 16'hFF00);
      write_reg(CSR_LONG_HOLD, 16'd0);
      write_reg(CSR_REPEAT, 16'h5500);
      write_reg(CSR_REP_EN, 16'hFFFF);
      send_poll(16'd2000, 1'b0);
      send_poll(16'd2001, 1'b0);
      send_poll(16'd2001, 1'b0);
      send_poll(16'd2002, 1'b0);
      send_poll(16'd2003, 1'b0);
      send_poll(16'd2003, 1'b1);
      send_poll(16'd2004, 1'b1);
      send_poll(16'hFFFF, 1'b0);
      send_poll(16'd0, 1'b0);        // time wraps between the two polls
      send_poll(16'd1, 1'b1);
      send_poll(16'd2, 1'b1);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               deb = '0; hold = '0; rep = '0; en = 1'b1;
            end
            1: begin
               deb = '1; hold = '1; rep = '1; en = 1'b0;
            end
            2: begin
               deb = '1; hold = TIME_W'($urandom_range(0, 600)); rep = '1; en = 1'b1;
            end
            default: begin
               deb  = ($urandom_range(0, 7) == 0) ? '1 : DEB_W'($urandom_range(0, 40));
               hold = TIME_W'($urandom_range(0, 600));
               rep  = REP_W'($urandom);
               en   = 1'($urandom);
            end
         endcase
         configure(deb, hold, rep, en, SRC_W'($urandom));
         gap_max   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 12 : $urandom_range(0, 12);
         stall_max = (p % 3 == 1) ? 0 : (p % 3 == 2) ? 12 : $urandom_range(0, 12);
         now_ms    = (p == 3) ? 16'hFF00 : TIME_W'($urandom);
         phase_end = polls_sent + 165;
         paused    = 1'b0;
         while (polls_sent < phase_end) begin
            if (!paused && polls_sent + 80 > phase_end) begin
               // let the pipeline run dry mid-sequence, then change the pacing
               wait_drained();
               paused    = 1'b1;
               gap_max   = $urandom_range(0, 12);
               stall_max = $urandom_range(0, 12);
            end
            if ($urandom_range(0, 3) == 0)
               noise_burst();
            else
               press_gesture();
         end
      end

      settle();
      if (tracker.mismatch_count == 0 && tracker.pending_events.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
